@@ design/yhsla_pkg.sv @@
// ----------------------------------------------------------------------------
// yhsla_pkg
// Shared widths, register codes and types for the YCbCr hue, saturation and
// luma adjust block.
// ----------------------------------------------------------------------------
package yhsla_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 12;
    localparam int PIX_W              = 8;
    localparam int GAIN_W             = 16;
    localparam int LUT_DEPTH          = 256;
    localparam int LUT_AW             = 8;
    localparam int APB_ADDR_W         = 4;
    localparam int APB_DATA_W         = 32;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TABLE = 1'b1;

    localparam logic signed [GAIN_W-1:0] COS_GAIN_RST = 16'sd4096;
    localparam logic signed [GAIN_W-1:0] SIN_GAIN_RST = 16'sd0;

    typedef enum logic [1:0] {
        REG_ADJUST_LUMA = 2'd0,
        REG_COS_GAIN    = 2'd1,
        REG_SIN_GAIN    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                     adjust_luma;
        logic signed [GAIN_W-1:0] cos_gain;
        logic signed [GAIN_W-1:0] sin_gain;
    } cfg_t;

    // Per-stage load enables of the pixel pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

@@ design/yhsla_if.sv @@
// ----------------------------------------------------------------------------
// yhsla_if
// Valid/ready stream interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface yhsla_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [yhsla_pkg::PIX_W-1:0] luma;
    logic [yhsla_pkg::PIX_W-1:0] cb;
    logic [yhsla_pkg::PIX_W-1:0] cr;
    logic [yhsla_pkg::LUT_AW-1:0] table_index;
    logic [yhsla_pkg::PIX_W-1:0] table_value;

    modport source (output valid, kind, luma, cb, cr, table_index, table_value,
                    input ready);
    modport sink   (input valid, kind, luma, cb, cr, table_index, table_value,
                    output ready);
endinterface

interface yhsla_out_if;
    logic                        valid;
    logic                        ready;
    logic [yhsla_pkg::PIX_W-1:0] luma_out;
    logic [yhsla_pkg::PIX_W-1:0] cb_out;
    logic [yhsla_pkg::PIX_W-1:0] cr_out;

    modport source (output valid, luma_out, cb_out, cr_out, input ready);
    modport sink   (input valid, luma_out, cb_out, cr_out, output ready);
endinterface

@@ design/yhsla_apb_regs.sv @@
// ----------------------------------------------------------------------------
// yhsla_apb_regs
// APB register file: luma adjust enable and the two chroma gains.
// ----------------------------------------------------------------------------
module yhsla_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [yhsla_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [yhsla_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [yhsla_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output yhsla_pkg::cfg_t                   cfg
);
    import yhsla_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ADJUST_LUMA: cfg_next.adjust_luma = pwdata[0];
                REG_COS_GAIN:    cfg_next.cos_gain    = pwdata[GAIN_W-1:0];
                REG_SIN_GAIN:    cfg_next.sin_gain    = pwdata[GAIN_W-1:0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ADJUST_LUMA: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_reg.adjust_luma};
            REG_COS_GAIN:    prdata = APB_DATA_W'(cfg_reg.cos_gain);
            REG_SIN_GAIN:    prdata = APB_DATA_W'(cfg_reg.sin_gain);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adjust_luma <= 1'b0;
            cfg_reg.cos_gain    <= COS_GAIN_RST;
            cfg_reg.sin_gain    <= SIN_GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/yhsla_luma_lut.sv @@
// ----------------------------------------------------------------------------
// yhsla_luma_lut
// Luma curve memory and the luma lane of the pixel pipeline.
// ----------------------------------------------------------------------------
module yhsla_luma_lut (
    input  logic                           clk,
    input  yhsla_pkg::stage_en_t           en,
    input  logic                           wr,
    input  logic                           adjust_luma,
    input  logic [yhsla_pkg::PIX_W-1:0]    luma,
    input  logic [yhsla_pkg::LUT_AW-1:0]   table_index,
    input  logic [yhsla_pkg::PIX_W-1:0]    table_value,
    output logic [yhsla_pkg::PIX_W-1:0]    luma_out
);
    import yhsla_pkg::*;

    logic [PIX_W-1:0]  mem [LUT_DEPTH];
    logic [PIX_W-1:0]  luma1_reg;
    logic [LUT_AW-1:0] idx1_reg;
    logic [PIX_W-1:0]  val1_reg;
    logic [PIX_W-1:0]  rdata_reg;
    logic [PIX_W-1:0]  luma2_reg;
    logic [PIX_W-1:0]  luma3_reg;
    logic [PIX_W-1:0]  luma3_next;
    logic [PIX_W-1:0]  luma4_reg;

    assign luma3_next = adjust_luma ? rdata_reg : luma2_reg;
    assign luma_out   = luma4_reg;

    // Table write and pixel lookup both happen at the second stage, on separate addresses.
    always_ff @(posedge clk)
    begin
        if (wr)
            mem[idx1_reg] <= val1_reg;
        if (en.s2)
            rdata_reg <= mem[luma1_reg];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            luma1_reg <= luma;
            idx1_reg  <= table_index;
            val1_reg  <= table_value;
        end
        if (en.s2)
            luma2_reg <= luma1_reg;
        if (en.s3)
            luma3_reg <= luma3_next;
        if (en.s4)
            luma4_reg <= luma3_reg;
    end

endmodule

@@ design/yhsla_chroma.sv @@
// ----------------------------------------------------------------------------
// yhsla_chroma
// Chroma rotate and scale: offset, multiply, sum with rounding bias, clamp.
// ----------------------------------------------------------------------------
module yhsla_chroma #(
    parameter int GAIN_FRAC_BITS = yhsla_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  yhsla_pkg::stage_en_t        en,
    input  yhsla_pkg::cfg_t             cfg,
    input  logic [yhsla_pkg::PIX_W-1:0] cb,
    input  logic [yhsla_pkg::PIX_W-1:0] cr,
    output logic [yhsla_pkg::PIX_W-1:0] cb_out,
    output logic [yhsla_pkg::PIX_W-1:0] cr_out
);
    import yhsla_pkg::*;

    localparam int PROD_W = PIX_W + GAIN_W;
    localparam int BIAS_W = GAIN_FRAC_BITS + PIX_W + 1;
    localparam int SUM_W  = ((BIAS_W > PROD_W + 1) ? BIAS_W : PROD_W + 1) + 1;
    localparam int Q_W    = SUM_W - GAIN_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS =
        SUM_W'((128 << GAIN_FRAC_BITS) + (1 << (GAIN_FRAC_BITS - 1)));

    logic signed [PIX_W-1:0]  u1_reg;
    logic signed [PIX_W-1:0]  v1_reg;
    logic signed [PROD_W-1:0] uc2_reg;
    logic signed [PROD_W-1:0] vs2_reg;
    logic signed [PROD_W-1:0] vc2_reg;
    logic signed [PROD_W-1:0] us2_reg;
    logic signed [SUM_W-1:0]  cb3_reg;
    logic signed [SUM_W-1:0]  cr3_reg;
    logic signed [SUM_W-1:0]  cb3_next;
    logic signed [SUM_W-1:0]  cr3_next;
    logic [PIX_W-1:0]         cb4_reg;
    logic [PIX_W-1:0]         cr4_reg;

    // Floor by the fraction bits, then clamp to the pixel range.
    function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] t);
        logic [Q_W-1:0] q;
        q = t[SUM_W-1:GAIN_FRAC_BITS];
        if (t[SUM_W-1])
            return '0;
        else if (|q[Q_W-1:PIX_W])
            return '1;
        else
            return q[PIX_W-1:0];
    endfunction

    assign cb3_next = SUM_W'(uc2_reg) + SUM_W'(vs2_reg) + ROUND_BIAS;
    assign cr3_next = SUM_W'(vc2_reg) - SUM_W'(us2_reg) + ROUND_BIAS;
    assign cb_out   = cb4_reg;
    assign cr_out   = cr4_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            // Remove the 128 offset: flip the top bit.
            u1_reg <= {~cb[PIX_W-1], cb[PIX_W-2:0]};
            v1_reg <= {~cr[PIX_W-1], cr[PIX_W-2:0]};
        end
        if (en.s2)
        begin
            uc2_reg <= u1_reg * cfg.cos_gain;
            vs2_reg <= v1_reg * cfg.sin_gain;
            vc2_reg <= v1_reg * cfg.cos_gain;
            us2_reg <= u1_reg * cfg.sin_gain;
        end
        if (en.s3)
        begin
            cb3_reg <= cb3_next;
            cr3_reg <= cr3_next;
        end
        if (en.s4)
        begin
            cb4_reg <= clamp_pix(cb3_reg);
            cr4_reg <= clamp_pix(cr3_reg);
        end
    end

endmodule

@@ design/ycbcr_hue_sat_luma_adjust.sv @@
// Pipeline: four register stages; a pixel accepted at the input passes through stages one
// to four in order and is shown on the output from the fourth.
// Throughput: one item per cycle; every stage advances whenever its successor is empty or
// moves on, so only a stalled output holds the input back.
// Table-write items give no result and leave the pipeline after the first stage.
// Reset (rst_n, async, active low) empties the pipeline and loads the register defaults;
// the luma curve is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// ycbcr_hue_sat_luma_adjust
// Per-pixel YCbCr adjust: luma through an optional curve, chroma rotated and
// scaled about 128 by signed fixed-point gains with rounding and clamping.
// ----------------------------------------------------------------------------
module ycbcr_hue_sat_luma_adjust #(
    parameter int GAIN_FRAC_BITS = yhsla_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    yhsla_in_if.sink                          pix_in,
    yhsla_out_if.source                       pix_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [yhsla_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [yhsla_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [yhsla_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import yhsla_pkg::*;

    cfg_t      cfg;
    stage_en_t en;

    // Stage valid bits; kind rides along only through stage one.
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic v4_reg, v4_next;
    logic kind1_reg, kind1_next;
    logic ready1, ready2, ready3, ready4;
    logic lut_wr;

    // A stage takes new data when it is empty or its contents move on.
    assign ready4 = !v4_reg || pix_out.ready;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    always_comb
    begin
        en.s1 = ready1;
        en.s2 = ready2;
        en.s3 = ready3;
        en.s4 = ready4;
    end

    assign pix_in.ready  = ready1;
    assign pix_out.valid = v4_reg;

    // Drop table writes here: they update the curve and make no result.
    assign lut_wr     = en.s2 && v1_reg && (kind1_reg == KIND_TABLE);
    assign v1_next    = en.s1 ? pix_in.valid : v1_reg;
    assign kind1_next = en.s1 ? pix_in.kind  : kind1_reg;
    assign v2_next    = en.s2 ? (v1_reg && (kind1_reg == KIND_PIXEL)) : v2_reg;
    assign v3_next    = en.s3 ? v2_reg : v3_reg;
    assign v4_next    = en.s4 ? v3_reg : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            kind1_reg <= KIND_PIXEL;
        end
        else
        begin
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            v3_reg    <= v3_next;
            v4_reg    <= v4_next;
            kind1_reg <= kind1_next;
        end
    end

    yhsla_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    yhsla_luma_lut u_luma (
        .clk         (clk),
        .en          (en),
        .wr          (lut_wr),
        .adjust_luma (cfg.adjust_luma),
        .luma        (pix_in.luma),
        .table_index (pix_in.table_index),
        .table_value (pix_in.table_value),
        .luma_out    (pix_out.luma_out)
    );

    yhsla_chroma #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_chroma (
        .clk    (clk),
        .en     (en),
        .cfg    (cfg),
        .cb     (pix_in.cb),
        .cr     (pix_in.cr),
        .cb_out (pix_out.cb_out),
        .cr_out (pix_out.cr_out)
    );

endmodule

@@ design/yhsla_checker.sv @@
// ----------------------------------------------------------------------------
// yhsla_checker
// Port-level checks of the adjust block, bound to the top level.
// ----------------------------------------------------------------------------
module yhsla_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        in_kind,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [yhsla_pkg::PIX_W-1:0] luma_out,
    input logic [yhsla_pkg::PIX_W-1:0] cb_out,
    input logic [yhsla_pkg::PIX_W-1:0] cr_out,
    input logic                        pready
);
    import yhsla_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({luma_out, cb_out, cr_out}))
        else $error("result payload changed while stalled");

    // An empty output stage means the whole pipeline can advance.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // An accepted pixel reaches the output when the receiver stays ready while it moves through.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind == KIND_PIXEL) ##1 out_ready ##1 out_ready
        ##1 out_ready |=> out_valid)
        else $error("pixel did not arrive in time");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind ycbcr_hue_sat_luma_adjust yhsla_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .in_kind   (pix_in.kind),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .luma_out  (pix_out.luma_out),
    .cb_out    (pix_out.cb_out),
    .cr_out    (pix_out.cr_out),
    .pready    (pready)
);

@@ sim/yhsla_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yhsla_chk
// Watches the pixel channels and the register port of the adjust block, keeps
// its own copy of the registers and the luma curve, predicts each adjusted
// pixel and compares it against what comes out.
// ----------------------------------------------------------------------------
module yhsla_chk #(
    parameter int GAIN_FRAC_BITS = yhsla_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    yhsla_in_if                              pix_in,
    yhsla_out_if                             pix_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [yhsla_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [yhsla_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                             pready,
    output int                               mismatches,
    output int                               pending
);
    import yhsla_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
    } pixel_t;

    cfg_t             cfg_copy;
    logic [PIX_W-1:0] curve [LUT_DEPTH];
    pixel_t           adjusted_q [$];

    // Rotate and scale one chroma sample about 128, round, floor and clamp.
    function automatic logic [PIX_W-1:0] rotate_chroma(int a, int b, int g1, int g2);
        longint t;
        t = longint'(a) * g1 + longint'(b) * g2
          + (longint'(128) << GAIN_FRAC_BITS) + (longint'(1) << (GAIN_FRAC_BITS - 1));
        if (t < 0)
            return '0;
        t = t >>> GAIN_FRAC_BITS;
        return (t > 255) ? 8'd255 : t[PIX_W-1:0];
    endfunction

    function automatic pixel_t adjust_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] cb,
                                            logic [PIX_W-1:0] cr);
        pixel_t p;
        int     u;
        int     v;
        int     gc;
        int     gs;
        u      = int'({1'b0, cb}) - 128;
        v      = int'({1'b0, cr}) - 128;
        gc     = int'(cfg_copy.cos_gain);
        gs     = int'(cfg_copy.sin_gain);
        p.luma = cfg_copy.adjust_luma ? curve[y] : y;
        p.cb   = rotate_chroma(u, v, gc, gs);
        p.cr   = rotate_chroma(v, u, gc, -gs);
        return p;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pixel_t want;
        pixel_t got;
        if (!rst_n) begin
            cfg_copy.adjust_luma = 1'b0;
            cfg_copy.cos_gain    = COS_GAIN_RST;
            cfg_copy.sin_gain    = SIN_GAIN_RST;
            adjusted_q.delete();
            foreach (curve[i])
                curve[i] = '0;
            mismatches = 0;
            pending    = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ADJUST_LUMA: cfg_copy.adjust_luma = pwdata[0];
                    REG_COS_GAIN:    cfg_copy.cos_gain    = pwdata[GAIN_W-1:0];
                    REG_SIN_GAIN:    cfg_copy.sin_gain    = pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // Pop before push: a pixel taken at this edge cannot leave at the same edge.
            if (pix_out.valid && pix_out.ready) begin
                got = '{pix_out.luma_out, pix_out.cb_out, pix_out.cr_out};
                if (adjusted_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("chk: unexpected pixel y=%0d cb=%0d cr=%0d",
                                 got.luma, got.cb, got.cr);
                end else begin
                    want = adjusted_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("chk: mismatch exp y=%0d cb=%0d cr=%0d got y=%0d cb=%0d cr=%0d",
                                     want.luma, want.cb, want.cr, got.luma, got.cb, got.cr);
                    end
                end
            end

            if (pix_in.valid && pix_in.ready) begin
                if (pix_in.kind == KIND_TABLE)
                    curve[pix_in.table_index] = pix_in.table_value;
                else
                    adjusted_q.push_back(adjust_pixel(pix_in.luma, pix_in.cb, pix_in.cr));
            end
            pending = adjusted_q.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the YCbCr hue, saturation and luma adjust block:
// directed corner pixels and curve writes, then random segments under several
// register settings and handshake pressure, checked by yhsla_chk.
// ----------------------------------------------------------------------------
module tb;
    import yhsla_pkg::*;

    localparam int REG_PAST_END  = 3;       // index beyond the register list
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEGMENTS      = 9;
    localparam int SEG_ITEMS     = 150;
    localparam int SETTLE_CYCLES = 8;       // covers the four pipeline stages

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int n_pixels;
    int n_writes;
    int n_settings;

    // Mirror of the register and curve state the stimulus needs to stay legal.
    logic             adj_on;
    logic             curve_written [LUT_DEPTH];
    logic [PIX_W-1:0] written_idx [$];

    yhsla_in_if  pix_in_if ();
    yhsla_out_if pix_out_if ();

    ycbcr_hue_sat_luma_adjust u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_if),
        .pix_out (pix_out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    yhsla_chk u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in_if),
        .pix_out    (pix_out_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run as failed if it never drains.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: timeout after %0d cycles", cycles);
        $display("tb: done, errors");
        $finish;
    end

    // Receiver: drop ready at random according to the current pressure.
    initial begin
        pix_out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            pix_out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Drive one item and hold it until the block takes it.
    task automatic send_item(input logic kind, input logic [PIX_W-1:0] y,
                             input logic [PIX_W-1:0] cb, input logic [PIX_W-1:0] cr,
                             input logic [LUT_AW-1:0] idx, input logic [PIX_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_in_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in_if.valid       <= 1'b1;
        pix_in_if.kind        <= kind;
        pix_in_if.luma        <= y;
        pix_in_if.cb          <= cb;
        pix_in_if.cr          <= cr;
        pix_in_if.table_index <= idx;
        pix_in_if.table_value <= val;
        do
            @(posedge clk);
        while (!pix_in_if.ready);
        if (kind == KIND_TABLE) begin
            n_writes++;
            if (!curve_written[idx]) begin
                curve_written[idx] = 1'b1;
                written_idx.push_back(idx);
            end
        end else begin
            n_pixels++;
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] y, input logic [PIX_W-1:0] cb,
                              input logic [PIX_W-1:0] cr);
        send_item(KIND_PIXEL, y, cb, cr, LUT_AW'($urandom), PIX_W'($urandom));
    endtask

    task automatic send_curve(input logic [LUT_AW-1:0] idx, input logic [PIX_W-1:0] val);
        send_item(KIND_TABLE, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), idx, val);
    endtask

    // Hold off until every pixel is out and any trailing curve write has left
    // the first stage, so a register write lands on an idle block.
    task automatic wait_idle();
        pix_in_if.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup phase, access phase until pready, then psel is dropped before the next transfer.
    task automatic reg_write(input int index, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(index * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic adj, input logic signed [GAIN_W-1:0] gc,
                                 input logic signed [GAIN_W-1:0] gs);
        wait_idle();
        reg_write(REG_ADJUST_LUMA, {31'($urandom), adj});
        reg_write(REG_COS_GAIN, {{(APB_DATA_W-GAIN_W){gc[GAIN_W-1]}}, gc});
        reg_write(REG_SIN_GAIN, {{(APB_DATA_W-GAIN_W){gs[GAIN_W-1]}}, gs});
        adj_on = adj;
        n_settings++;
    endtask

    // Chroma sample biased now and then toward the clamp edges or toward 128.
    function automatic logic [PIX_W-1:0] pick_chroma();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return PIX_W'($urandom_range(136, 120));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // With the curve in use, only look up entries that hold a written byte.
    function automatic logic [PIX_W-1:0] pick_luma();
        if (adj_on)
            return written_idx[$urandom_range(written_idx.size() - 1)];
        return PIX_W'($urandom);
    endfunction

    function automatic logic signed [GAIN_W-1:0] rand_gain(input int span);
        return GAIN_W'($urandom_range(2 * span) - span);
    endfunction

    initial begin
        logic                     seg_adj;
        logic signed [GAIN_W-1:0] seg_cos;
        logic signed [GAIN_W-1:0] seg_sin;

        rst_n                  = 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        pix_in_if.valid       <= 1'b0;
        pix_in_if.kind        <= KIND_PIXEL;
        pix_in_if.luma        <= '0;
        pix_in_if.cb          <= '0;
        pix_in_if.cr          <= '0;
        pix_in_if.table_index <= '0;
        pix_in_if.table_value <= '0;
        send_idle_pct          = 0;
        recv_idle_pct          = 0;
        n_pixels               = 0;
        n_writes               = 0;
        n_settings             = 0;
        adj_on                 = 1'b0;
        foreach (curve_written[i])
            curve_written[i] = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers give unity gains and a bypassed curve,
        // so these pixels must pass through unchanged.
        send_curve(8'd0, 8'd255);
        send_curve(8'd255, 8'd0);
        send_curve(8'h55, 8'hAA);
        send_curve(8'hAA, 8'h55);
        send_curve(8'd128, 8'd128);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'h55, 8'd0, 8'd255);

        // A write past the register list must leave everything as it was.
        wait_idle();
        reg_write(REG_PAST_END, 32'hFFFF_FFFF);
        send_pixel(8'hAA, 8'd255, 8'd0);

        // Extreme gains, curve on: drive both clamps and the curve corners.
        apply_setting(1'b1, 16'sh7FFF, 16'sh8000);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd0, 8'd255);
        send_pixel(8'h55, 8'd255, 8'd0);
        send_pixel(8'hAA, 8'd128, 8'd128);
        send_curve(8'd128, 8'd7);
        send_pixel(8'd128, 8'd129, 8'd127);

        apply_setting(1'b1, 16'sh8000, 16'sh7FFF);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd128, 8'd127, 8'd129);

        // Random segments: pressure by thirds, a fresh setting per segment.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: begin seg_adj = 1'b1; seg_cos = 16'sd4096;  seg_sin = 16'sd0;      end
                1: begin seg_adj = 1'b0; seg_cos = 16'sh8000;  seg_sin = 16'sh7FFF;   end
                2: begin seg_adj = 1'b1; seg_cos = rand_gain(8192); seg_sin = rand_gain(8192); end
                3: begin seg_adj = 1'b1; seg_cos = 16'sh7FFF;  seg_sin = 16'sh8000;   end
                4: begin seg_adj = 1'b0; seg_cos = 16'sd0;     seg_sin = 16'sd0;      end
                5: begin seg_adj = 1'b1; seg_cos = -16'sd4096; seg_sin = 16'sd0;      end
                6: begin seg_adj = 1'b0; seg_cos = rand_gain(32767); seg_sin = rand_gain(32767); end
                7: begin seg_adj = 1'b1; seg_cos = 16'sd2896;  seg_sin = 16'sd2896;   end
                default: begin seg_adj = 1'b1; seg_cos = rand_gain(6000); seg_sin = rand_gain(6000); end
            endcase
            apply_setting(seg_adj, seg_cos, seg_sin);

            if (seg < 3) begin
                send_idle_pct = 13;
                recv_idle_pct = 82;
            end else if (seg < 6) begin
                send_idle_pct = 82;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int k = 0; k < SEG_ITEMS; k++) begin
                if ($urandom_range(4) == 0)
                    send_curve(LUT_AW'($urandom), PIX_W'($urandom));
                else
                    send_pixel(pick_luma(), pick_chroma(), pick_chroma());
            end
        end

        // Drain: keep the receiver live, then give stragglers time to show up.
        pix_in_if.valid <= 1'b0;
        recv_idle_pct    = 13;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d pixels and %0d curve writes under %0d register settings",
                 n_pixels, n_writes, n_settings);
        $display("tb: %0d curve entries written, %0d mismatches", written_idx.size(),
                 mismatches);
        if (mismatches == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
design/yhsla_pkg.sv
design/yhsla_if.sv
design/yhsla_apb_regs.sv
design/yhsla_luma_lut.sv
design/yhsla_chroma.sv
design/ycbcr_hue_sat_luma_adjust.sv
design/yhsla_checker.sv
sim/yhsla_chk.sv
sim/tb.sv
